// ===== design/fir_filter_truncating_saturating_unit_assert.svh =====
// Assertion macros for the truncating, saturating FIR filter.
// Included by the top level; depends on nothing else.
`ifndef FIR_FILTER_TRUNCATING_SATURATING_UNIT_ASSERT_SVH
`define FIR_FILTER_TRUNCATING_SATURATING_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define FTS_ASSERT(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("fts assertion failed");

// A condition that, once seen, must be followed by another in the next cycle.
`define FTS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fts assertion failed");

`endif

// ===== design/fts_pkg.sv =====
// Shared types, widths and the coefficient table of the FIR filter.
// Used by the tap cell, the adder tree and the top level.
package fts_pkg;

  localparam int SAMPLE_BITS = 9;
  localparam int COEF_W      = 8;
  localparam int ADDED_SHIFT = 2;
  localparam int BASE_TAPS   = 11;

  // Product of a sample and a coefficient, and the truncated term kept per tap.
  localparam int PROD_W     = SAMPLE_BITS + COEF_W;
  localparam int TERM_SHIFT = SAMPLE_BITS - 1 + ADDED_SHIFT;
  localparam int TERM_W     = COEF_W - 1;

  localparam int SAMPLE_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SAMPLE_MIN = -(1 << (SAMPLE_BITS - 1));

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          sample_valid;
  } fts_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered_out;
    logic                          out_valid;
  } fts_out_t;

  // Symmetric coefficient set; taps past the base set carry zero.
  function automatic logic signed [COEF_W-1:0] tap_coef(input int unsigned idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      0, 10:   c = -8'sd1;
      1, 9:    c = -8'sd4;
      2, 8:    c = -8'sd7;
      3, 7:    c = 8'sd16;
      4, 6:    c = 8'sd70;
      5:       c = 8'sd101;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== design/fts_tap_cell.sv =====
// One tap of the delay line: holds a sample, hands it to the next tap on a
// shift and registers its truncated product term. Depends on fts_pkg.
module fts_tap_cell #(
  parameter int unsigned TAP_IDX = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  shift_i,
  input  logic                                  load_i,
  input  logic signed [fts_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic signed [fts_pkg::SAMPLE_BITS-1:0] sample_o,
  output logic signed [fts_pkg::TERM_W-1:0]      term_o
);
  import fts_pkg::*;

  localparam logic signed [COEF_W-1:0] TapCoef = tap_coef(TAP_IDX);

  logic signed [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic signed [PROD_W-1:0]      prod, prod_shr;
  logic signed [TERM_W-1:0]      term_q;

  // The delay line moves by one place when a valid sample comes in.
  assign sample_d = shift_i ? sample_i : sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else begin
      sample_q <= sample_d;
    end
  end

  // Product with the fixed coefficient, floored by the combined right shift.
  always_comb begin
    prod     = PROD_W'(sample_d) * PROD_W'(TapCoef);
    prod_shr = prod >>> TERM_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      term_q <= prod_shr[TERM_W-1:0];
    end
  end

  assign sample_o = sample_q;
  assign term_o   = term_q;

endmodule

// ===== design/fts_add_tree.sv =====
// Pipelined binary adder tree with a valid/ready handshake between levels.
// Sums the tap terms and carries the result flag along. Depends on fts_pkg.
module fts_add_tree #(
  parameter int N_IN = 11,
  parameter int IN_W = 7,
  parameter int OUT_W = IN_W + $clog2(N_IN)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   flag_i,
  input  logic signed [IN_W-1:0] terms_i [N_IN],
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   flag_o,
  output logic signed [OUT_W-1:0] sum_o
);
  import fts_pkg::*;

  localparam int Levels = $clog2(N_IN);
  localparam int Nodes  = (1 << Levels) - 1;

  logic [Levels-1:0] vld_q;
  logic [Levels-1:0] flag_q;
  logic [Levels:0]   ready;
  logic signed [OUT_W-1:0] node_sum [Nodes];

  // Each level advances when it is empty or the next level takes its contents.
  always_comb begin
    ready[Levels] = out_ready_i;
    for (int s = Levels - 1; s >= 0; s--) begin
      ready[s] = !vld_q[s] || ready[s+1];
    end
  end

  // Valid and flag bits move with the data, level by level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      flag_q <= '0;
    end else begin
      if (ready[0]) begin
        vld_q[0]  <= in_valid_i;
        flag_q[0] <= flag_i;
      end
      for (int s = 1; s < Levels; s++) begin
        if (ready[s]) begin
          vld_q[s]  <= vld_q[s-1];
          flag_q[s] <= flag_q[s-1];
        end
      end
    end
  end

  // Nodes in heap order: node 0 is the root, leaves beyond the array are terms.
  for (genvar n = 0; n < Nodes; n++) begin : g_node
    localparam int Depth = $clog2(n + 2) - 1;
    localparam int Stage = Levels - 1 - Depth;
    localparam int ChA   = 2 * n + 1;
    localparam int ChB   = 2 * n + 2;

    logic signed [OUT_W-1:0] opa, opb, sum_q;

    if (ChA >= Nodes) begin : g_leaf_a
      if (ChA - Nodes < N_IN) begin : g_term
        assign opa = OUT_W'(terms_i[ChA-Nodes]);
      end else begin : g_pad
        assign opa = '0;
      end
    end else begin : g_inner_a
      assign opa = node_sum[ChA];
    end

    if (ChB >= Nodes) begin : g_leaf_b
      if (ChB - Nodes < N_IN) begin : g_term
        assign opb = OUT_W'(terms_i[ChB-Nodes]);
      end else begin : g_pad
        assign opb = '0;
      end
    end else begin : g_inner_b
      assign opb = node_sum[ChB];
    end

    always_ff @(posedge clk_i) begin
      if (ready[Stage]) begin
        sum_q <= opa + opb;
      end
    end

    assign node_sum[n] = sum_q;
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = vld_q[Levels-1];
  assign flag_o      = flag_q[Levels-1];
  assign sum_o       = node_sum[0];

endmodule

// ===== design/fir_filter_truncating_saturating_unit.sv =====
// Top level of the truncating, saturating FIR filter: tap cells, adder tree
// and output register. Depends on fts_pkg, fts_tap_cell and fts_add_tree.
//
// Usage: requests arrive on in_valid_i/in_ready_o with payload in_req_i and
// results leave on out_valid_o/out_ready_i with payload out_res_o. Every
// accepted request gives exactly one result, in order. A request whose
// sample_valid bit is set shifts its sample into the delay line and advances
// the fill count, which stops at NUM_TAPS; a request without it leaves the
// delay line alone and still yields the filter output of the held samples.
// The out_valid field is set once NUM_TAPS valid samples have arrived and the
// request itself carried a valid sample.
// After a request is accepted, its tap products are captured at the accepting
// edge, then registered at each adder tree level in turn and, after saturation,
// in the output register; a stalled receiver can hold a result in any of them.
// Throughput: one request per cycle; every level of the tree hands off on its
// own handshake, so the block keeps accepting while a result waits, until
// all levels are full.
// Reset clears the delay line, the fill count and all valid bits.
module fir_filter_truncating_saturating_unit #(
  parameter int NUM_TAPS = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fts_pkg::fts_in_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fts_pkg::fts_out_t out_res_o
);
  import fts_pkg::*;

  `include "fir_filter_truncating_saturating_unit_assert.svh"

  localparam int FillW = $clog2(NUM_TAPS + 1);
  localparam int AccW  = TERM_W + $clog2(NUM_TAPS);
  localparam int CmpW  = AccW + ADDED_SHIFT + SAMPLE_BITS;
  localparam logic [FillW-1:0]     FillFull = FillW'(NUM_TAPS);
  localparam logic [FillW-1:0]     FillLast = FillW'(NUM_TAPS - 1);
  localparam logic signed [CmpW-1:0] SatHi = CmpW'(SAMPLE_MAX);
  localparam logic signed [CmpW-1:0] SatLo = CmpW'(SAMPLE_MIN);

  logic in_accept, shift;
  logic [FillW-1:0] fill_q, fill_d;
  logic p_valid_q, p_flag_q, p_ready;
  logic signed [SAMPLE_BITS-1:0] tap_sample [NUM_TAPS];
  logic signed [TERM_W-1:0]      tap_term [NUM_TAPS];

  logic tree_in_ready, tree_out_valid, tree_out_ready, tree_flag;
  logic signed [AccW-1:0] tree_sum;

  logic out_valid_q;
  fts_out_t out_res_q, out_res_d;
  logic signed [CmpW-1:0] scaled;

  assign in_accept = in_valid_i && in_ready_o;
  assign shift     = in_accept && in_req_i.sample_valid;

  // Fill count of valid samples, held at NUM_TAPS once reached.
  always_comb begin
    fill_d = fill_q;
    if (shift && fill_q != FillFull) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Row of tap cells; each passes its sample on to the next tap.
  for (genvar i = 0; i < NUM_TAPS; i++) begin : g_tap
    logic signed [SAMPLE_BITS-1:0] chain_in;
    if (i == 0) begin : g_head
      assign chain_in = in_req_i.sample_in;
    end else begin : g_body
      assign chain_in = tap_sample[i-1];
    end

    fts_tap_cell #(
      .TAP_IDX(i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .load_i  (in_accept),
      .sample_i(chain_in),
      .sample_o(tap_sample[i]),
      .term_o  (tap_term[i])
    );
  end

  // Product stage: the tap terms hold one request until the tree takes it.
  assign p_ready    = !p_valid_q || tree_in_ready;
  assign in_ready_o = p_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_flag_q  <= 1'b0;
    end else if (p_ready) begin
      p_valid_q <= in_valid_i;
      p_flag_q  <= in_req_i.sample_valid && (fill_q == FillFull || fill_q == FillLast);
    end
  end

  fts_add_tree #(
    .N_IN (NUM_TAPS),
    .IN_W (TERM_W),
    .OUT_W(AccW)
  ) u_tree (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (p_valid_q),
    .in_ready_o (tree_in_ready),
    .flag_i     (p_flag_q),
    .terms_i    (tap_term),
    .out_valid_o(tree_out_valid),
    .out_ready_i(tree_out_ready),
    .flag_o     (tree_flag),
    .sum_o      (tree_sum)
  );

  // Scale the sum back up and clamp it to the sample range.
  always_comb begin
    scaled = CmpW'(tree_sum) <<< ADDED_SHIFT;
    out_res_d.out_valid = tree_flag;
    if (scaled > SatHi) begin
      out_res_d.filtered_out = SatHi[SAMPLE_BITS-1:0];
    end else if (scaled < SatLo) begin
      out_res_d.filtered_out = SatLo[SAMPLE_BITS-1:0];
    end else begin
      out_res_d.filtered_out = scaled[SAMPLE_BITS-1:0];
    end
  end

  // Output register parts the tree from the receiver.
  assign tree_out_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tree_out_ready) begin
      out_valid_q <= tree_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tree_out_valid && tree_out_ready) begin
      out_res_q <= out_res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // The fill count never passes the number of taps.
  `FTS_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= FillFull)
  // A flagged result can only exist once the delay line has filled.
  `FTS_ASSERT(a_flag_needs_full, clk_i, rst_ni,
              !(out_valid_q && out_res_q.out_valid) || fill_q == FillFull)
  // A valid sample below saturation advances the count by exactly one.
  `FTS_ASSERT_NEXT(a_fill_step, clk_i, rst_ni, shift && fill_q != FillFull,
                   fill_q == FillW'($past(fill_q) + 1'b1))

endmodule
